// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and round functions for the block encrypt core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

	localparam int ROUND_COUNT = 10;
	localparam int BLOCK_W     = 128;
	localparam int HALF_W      = 64;
	localparam int CFG_IDX_W   = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	// Per-stage round options
	typedef struct packed {
		logic pre_key;   // fold the initial key addition in ahead of the round
		logic last;      // final round: no column mixing
	} round_mode_t;

	localparam logic [7:0] GF_POLY = 8'h1B;

	localparam logic [7:0] SBOX_TAB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Doubling in GF(2^8): reduce when the top bit is set
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	// Byte i of the state sits at bits [127-8i -: 8]
	function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
		return s[BLOCK_W-1-8*i -: 8];
	endfunction

	// Substitute every byte and rotate row r left by r
	function automatic logic [BLOCK_W-1:0] sub_rotate(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] t;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[BLOCK_W-1-8*(4*r+c) -: 8] = SBOX_TAB[get_byte(s, 4*r + ((c + r) % 4))];
			end
		end
		return t;
	endfunction

	// Mix each column (bytes c, 4+c, 8+c, 12+c)
	function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] t;
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, c);
			a1 = get_byte(s, 4 + c);
			a2 = get_byte(s, 8 + c);
			a3 = get_byte(s, 12 + c);
			d0 = xtime(a0);
			d1 = xtime(a1);
			d2 = xtime(a2);
			d3 = xtime(a3);
			t[BLOCK_W-1-8*c -: 8]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
			t[BLOCK_W-1-8*(4+c) -: 8]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
			t[BLOCK_W-1-8*(8+c) -: 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
			t[BLOCK_W-1-8*(12+c) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/aes_ifs.sv =====
// ----------------------------------------------------------------------------
// aes_ifs
// Valid/ready channel interfaces: plaintext in, ciphertext out, key writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, output block_high, output block_low, input ready);
	modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;
	modport source (output valid, output cipher_high, output cipher_low, input ready);
	modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface aes_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [aes_pkg::CFG_IDX_W-1:0]  index;
	logic [63:0]                    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/aes_key_regs.sv =====
// ----------------------------------------------------------------------------
// aes_key_regs
// Holds the two 64-bit key halves written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	aes_cfg_if.sink                            cfg,
	output logic [aes_pkg::BLOCK_W-1:0]        key
);

	logic [aes_pkg::HALF_W-1:0] key_high_q;
	logic [aes_pkg::HALF_W-1:0] key_low_q;

	assign cfg.ready = 1'b1;
	assign key       = {key_high_q, key_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg.valid) begin
			unique case (aes_pkg::cfg_reg_t'(cfg.index))
				aes_pkg::REG_KEY_HIGH: key_high_q <= cfg.data;
				aes_pkg::REG_KEY_LOW:  key_low_q  <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round
// One pipeline stage: a full cipher round followed by its valid/data register.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aes_pkg::round_mode_t          mode,
	input  wire logic [aes_pkg::BLOCK_W-1:0]   key,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [aes_pkg::BLOCK_W-1:0]   in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [aes_pkg::BLOCK_W-1:0]        out_data
);

	logic                        valid_s1;
	logic [aes_pkg::BLOCK_W-1:0] data_s1;
	logic [aes_pkg::BLOCK_W-1:0] start;
	logic [aes_pkg::BLOCK_W-1:0] subbed;
	logic [aes_pkg::BLOCK_W-1:0] mixed;

	always_comb begin
		start  = mode.pre_key ? (in_data ^ key) : in_data;
		subbed = aes_pkg::sub_rotate(start);
		mixed  = mode.last ? subbed : aes_pkg::mix_columns(subbed);
	end

	// Stage is free when empty or when its content moves on this cycle
	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= mixed ^ key;
		end
	end

`ifndef SYNTH
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stage dropped or changed a stalled item");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty stage refused a transfer");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item not held in stage");
`endif

endmodule

`default_nettype wire

// ===== hdl/aes_style_block_encrypt_core.sv =====
// ----------------------------------------------------------------------------
// aes_style_block_encrypt_core
// Fixed-key AES-style block encryption, one round per pipeline stage.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                      Transfer
//  --------  ---  ---------------------------  ---------------------
//  blk_in    in   block_high, block_low        valid & ready
//  blk_out   out  cipher_high, cipher_low      valid & ready
//  cfg       in   index (0 key_high, 1 key_low), data   valid & ready
//
//  One stage per round, the initial key addition folded into the first
//  stage. Throughput is one block per cycle while blk_out is not stalled.
//  Reset clears all stage valid bits and both key halves to zero.
//  Each stage's ready is "empty or draining", so a stall at blk_out only
//  backs up as far as the bubbles allow and no item is lost or repeated.
//  cfg is always ready; change the key only while the pipe is empty.
//
`default_nettype none

module aes_style_block_encrypt_core (
	input  wire logic clk,
	input  wire logic arst_n,
	aes_in_if.sink    blk_in,
	aes_out_if.source blk_out,
	aes_cfg_if.sink   cfg
);

	localparam int N = aes_pkg::ROUND_COUNT;

	logic [aes_pkg::BLOCK_W-1:0] key;

	// Node i sits in front of stage i; node N is the output register side
	logic                        node_valid [N+1];
	logic                        node_ready [N+1];
	logic [aes_pkg::BLOCK_W-1:0] node_data  [N+1];

	aes_key_regs u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key)
	);

	// Input side
	assign node_valid[0] = blk_in.valid;
	assign node_data[0]  = {blk_in.block_high, blk_in.block_low};
	assign blk_in.ready  = node_ready[0];

	for (genvar i = 0; i < N; i++) begin : g_round
		aes_pkg::round_mode_t mode;

		assign mode.pre_key = (i == 0);
		assign mode.last    = (i == N - 1);

		aes_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.mode      (mode),
			.key       (key),
			.in_valid  (node_valid[i]),
			.in_ready  (node_ready[i]),
			.in_data   (node_data[i]),
			.out_valid (node_valid[i+1]),
			.out_ready (node_ready[i+1]),
			.out_data  (node_data[i+1])
		);
	end

	// Output side: the last stage register is the output register
	assign blk_out.valid       = node_valid[N];
	assign blk_out.cipher_high = node_data[N][aes_pkg::BLOCK_W-1 -: aes_pkg::HALF_W];
	assign blk_out.cipher_low  = node_data[N][aes_pkg::HALF_W-1:0];
	assign node_ready[N]       = blk_out.ready;

endmodule

`default_nettype wire
